// ----- src/drrb_pkg.sv -----
// ---------------------------------------------------------------------------
// drrb_pkg
// Shared types and constants of the DMA ring receive buffer.
// ---------------------------------------------------------------------------
package drrb_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned SIZE_W = 9;

  // Operation codes of an input beat
  typedef enum logic [1:0] {
    OP_RX    = 2'd0,
    OP_IDLE  = 2'd1,
    OP_READ  = 2'd2,
    OP_FLUSH = 2'd3
  } op_t;

  // Read answer codes
  typedef enum logic [1:0] {
    ST_BYTE   = 2'd0,
    ST_NODATA = 2'd1,
    ST_OVF    = 2'd2,
    ST_IDLE   = 2'd3
  } status_t;

  typedef struct packed {
    op_t               op;
    logic [BYTE_W-1:0] rx_byte;
  } req_t;

  typedef struct packed {
    status_t           status;
    logic [BYTE_W-1:0] data_byte;
  } rsp_t;

  // Controller to datapath
  typedef struct packed {
    logic item_go;   // input beat taken this cycle
    logic cfg_go;    // size register written this cycle
    logic out_load;  // fetched answer moves into the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_read;   // current input beat is a read request
    logic out_full;  // output register holds an answer
  } sts_t;

endpackage

// ----- src/drrb_ctrl.sv -----
// ---------------------------------------------------------------------------
// drrb_ctrl
// Handshake controller: takes beats and size writes, sequences the store
// read of a read request and hands the answer to the output register.
// ---------------------------------------------------------------------------
module drrb_ctrl
  import drrb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic rsp_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_FETCH = 2'b10
  } state_t;

  state_t state, state_next;

  // Handshake outputs; a size write wins over an input beat
  assign cfg_ready = (state == S_IDLE);
  assign req_stall = (state != S_IDLE) || cfg_valid;

  assign cmd.cfg_go   = cfg_valid && cfg_ready;
  assign cmd.item_go  = req_valid && !req_stall;
  assign cmd.out_load = (state == S_FETCH) && (!sts.out_full || !rsp_stall);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd.item_go && sts.is_read) state_next = S_FETCH;
      end
      S_FETCH: begin
        if (cmd.out_load) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- src/drrb_datapath.sv -----
// ---------------------------------------------------------------------------
// drrb_datapath
// Ring store, write/read positions, half and overflow flags, idle marker
// and the output register.
// ---------------------------------------------------------------------------
module drrb_datapath
  import drrb_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = 256,
  parameter int unsigned PTR_W       = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  output sts_t              sts,
  input  req_t              req,
  input  logic [SIZE_W-1:0] cfg_data,
  output rsp_t              rsp,
  output logic              rsp_valid,
  input  logic              rsp_stall
);

  localparam logic [SIZE_W-1:0] SIZE_TOP = SIZE_W'(STORE_DEPTH - (STORE_DEPTH % 2));
  localparam logic [SIZE_W-1:0] SIZE_MIN = SIZE_W'(2);
  localparam int unsigned       EXT_W    = SIZE_W - PTR_W;

  logic [BYTE_W-1:0] rx_store [STORE_DEPTH];
  logic [BYTE_W-1:0] store_q;

  logic [SIZE_W-1:0] ring_size, ring_size_next;
  logic [PTR_W-1:0]  write_pos, write_pos_next;
  logic [PTR_W-1:0]  read_pos, read_pos_next;
  logic [PTR_W-1:0]  idle_pos, idle_pos_next;
  logic              lower_half_full, lower_half_full_next;
  logic              upper_half_full, upper_half_full_next;
  logic              overflow_flag, overflow_flag_next;
  logic              idle_valid, idle_valid_next;
  status_t           pend_status, pend_status_next;

  logic [SIZE_W-1:0] half;
  logic [SIZE_W-1:0] wp_ext, rp_ext, wp_inc, rp_inc;
  logic [SIZE_W-1:0] size_masked;
  logic              lower_mid;

  assign half   = ring_size >> 1;
  assign wp_ext = {{EXT_W{1'b0}}, write_pos};
  assign rp_ext = {{EXT_W{1'b0}}, read_pos};
  assign wp_inc = wp_ext + SIZE_W'(1);
  assign rp_inc = rp_ext + SIZE_W'(1);
  assign size_masked = cfg_data & SIZE_W'(9'h1FE);

  assign sts.is_read  = (req.op == OP_READ);
  assign sts.out_full = rsp_valid;

  // Next state of positions and flags
  always_comb begin
    ring_size_next       = ring_size;
    write_pos_next       = write_pos;
    read_pos_next        = read_pos;
    idle_pos_next        = idle_pos;
    lower_half_full_next = lower_half_full;
    upper_half_full_next = upper_half_full;
    overflow_flag_next   = overflow_flag;
    idle_valid_next      = idle_valid;
    pend_status_next     = pend_status;
    lower_mid            = lower_half_full;

    if (cmd.cfg_go) begin
      // clamp the ring length to an even value inside the store
      priority if (size_masked < SIZE_MIN) ring_size_next = SIZE_MIN;
      else if (size_masked > SIZE_TOP)      ring_size_next = SIZE_TOP;
      else                                  ring_size_next = size_masked;
      write_pos_next       = '0;
      read_pos_next        = '0;
      lower_half_full_next = 1'b0;
      upper_half_full_next = 1'b0;
      overflow_flag_next   = 1'b0;
      idle_valid_next      = 1'b0;
    end else if (cmd.item_go) begin
      unique case (req.op)
        OP_RX: begin
          write_pos_next = wp_inc[PTR_W-1:0];
          if (wp_inc == half) begin
            if (lower_half_full || upper_half_full) overflow_flag_next = 1'b1;
            lower_mid = 1'b1;
          end
          lower_half_full_next = lower_mid;
          if (wp_inc >= ring_size) begin
            if (lower_mid || upper_half_full) overflow_flag_next = 1'b1;
            upper_half_full_next = 1'b1;
            write_pos_next       = '0;
          end
        end
        OP_IDLE: begin
          idle_valid_next = 1'b1;
          idle_pos_next   = write_pos;
        end
        OP_FLUSH: begin
          read_pos_next        = write_pos;
          lower_half_full_next = 1'b0;
          upper_half_full_next = 1'b0;
          overflow_flag_next   = 1'b0;
          idle_valid_next      = 1'b0;
        end
        OP_READ: begin
          pend_status_next = ST_NODATA;
          priority if (overflow_flag) begin
            pend_status_next = ST_OVF;
          end else if (idle_valid && (read_pos == idle_pos)) begin
            pend_status_next = ST_IDLE;
            idle_valid_next  = 1'b0;
          end else if (rp_ext < half) begin
            // lower half; its last byte waits for the half mark
            if (lower_half_full || (read_pos < write_pos)) begin
              if (!lower_half_full && (rp_inc == half)) begin
                pend_status_next = ST_NODATA;
              end else begin
                pend_status_next = ST_BYTE;
                read_pos_next    = rp_inc[PTR_W-1:0];
                if (rp_inc == half) lower_half_full_next = 1'b0;
              end
            end
          end else begin
            // upper half; wraps at the ring end
            if (upper_half_full || (read_pos < write_pos)) begin
              pend_status_next = ST_BYTE;
              read_pos_next    = rp_inc[PTR_W-1:0];
              if (rp_inc >= ring_size) begin
                read_pos_next        = '0;
                upper_half_full_next = 1'b0;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Control and position registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ring_size       <= SIZE_TOP;
      write_pos       <= '0;
      read_pos        <= '0;
      idle_pos        <= '0;
      lower_half_full <= 1'b0;
      upper_half_full <= 1'b0;
      overflow_flag   <= 1'b0;
      idle_valid      <= 1'b0;
    end else begin
      ring_size       <= ring_size_next;
      write_pos       <= write_pos_next;
      read_pos        <= read_pos_next;
      idle_pos        <= idle_pos_next;
      lower_half_full <= lower_half_full_next;
      upper_half_full <= upper_half_full_next;
      overflow_flag   <= overflow_flag_next;
      idle_valid      <= idle_valid_next;
    end
  end

  // Pending answer code, no reset needed
  always_ff @(posedge clk) begin
    pend_status <= pend_status_next;
  end

  // Ring store: write on a received byte, registered read at read_pos
  always_ff @(posedge clk) begin
    if (cmd.item_go && (req.op == OP_RX)) begin
      rx_store[write_pos] <= req.rx_byte;
    end
    if (cmd.item_go) begin
      store_q <= rx_store[read_pos];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_valid && !rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp.status    <= pend_status;
      rsp.data_byte <= (pend_status == ST_BYTE) ? store_q : '0;
    end
  end

endmodule

// ----- src/dma_ring_rx_buffer.sv -----
// ---------------------------------------------------------------------------
// dma_ring_rx_buffer
// Circular receive buffer with half/end marks, overflow and idle markers.
// ---------------------------------------------------------------------------
// Each beat on req is one operation: store a received byte, mark line idle,
// read, or flush. A received byte, an idle mark or a flush completes as it
// is accepted. A read is accepted in a cycle that decides the answer and
// starts a registered store read; in the next cycle the answer moves into
// the output register, later only while rsp is stalled with an answer still
// held. The output register lets the next beat be accepted while an answer
// waits on rsp. Writing the size register on cfg resets both positions and
// all flags; it is meant for idle periods. The store needs no clearing pass
// after reset, so beats are accepted from the first cycle.
module dma_ring_rx_buffer
  import drrb_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  req_t              req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output rsp_t              rsp,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [SIZE_W-1:0] cfg_data
);

  localparam int unsigned PTR_W = $clog2(STORE_DEPTH);

  cmd_t cmd;
  sts_t sts;

  drrb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .rsp_stall (rsp_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  drrb_datapath #(
    .STORE_DEPTH (STORE_DEPTH),
    .PTR_W       (PTR_W)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .req       (req),
    .cfg_data  (cfg_data),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall)
  );

  // A loaded answer shows up on rsp in the next cycle
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> rsp_valid)
    else $error("answer load did not raise rsp_valid");

  // A size write and an input beat never complete together
  a_cfg_excl: assert property (@(posedge clk) disable iff (rst)
    !(cmd.item_go && cmd.cfg_go))
    else $error("size write and input beat in one cycle");

  // An accepted read blocks the input for the fetch cycle
  a_read_busy: assert property (@(posedge clk) disable iff (rst)
    (cmd.item_go && sts.is_read) |=> req_stall)
    else $error("input not stalled during store fetch");

  // Reset leaves no answer pending
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("rsp_valid set after reset");

endmodule

// ----- bench/dma_ring_rx_buffer_chk.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// dma_ring_rx_buffer_chk
// Ring state tracker and answer scoreboard for the DMA ring receive buffer.
// ---------------------------------------------------------------------------
// Watches the req, rsp and cfg channels at the rising clock edge. It keeps its
// own copy of the ring: the byte store, both positions, the half marks, the
// overrun and idle marker. Every read beat queues the answer the ring should
// give. Every rsp beat is compared field by field with the oldest queued one.
module dma_ring_rx_buffer_chk
  import drrb_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  logic              req_stall,
  input  req_t              req,
  input  logic              rsp_valid,
  input  logic              rsp_stall,
  input  rsp_t              rsp,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [SIZE_W-1:0] cfg_data,
  output int                fail_count,
  output int                queued
);

  // Tracked ring state
  logic [BYTE_W-1:0] ring_mem [0:STORE_DEPTH-1];
  int unsigned       ring_len;
  int unsigned       wr_pos;
  int unsigned       rd_pos;
  int unsigned       mark_pos;
  bit                low_full;
  bit                high_full;
  bit                overrun;
  bit                mark_valid;

  rsp_t due_answers[$];
  int   errors = 0;

  assign fail_count = errors;

  // Size register: bit 0 dropped, kept within 2 .. even store depth
  function automatic int unsigned clamp_len(input logic [SIZE_W-1:0] v);
    int unsigned top;
    int unsigned sz;
    top = (STORE_DEPTH / 2) * 2;
    sz  = 32'({v[SIZE_W-1:1], 1'b0});
    if (sz < 2) sz = 2;
    if (sz > top) sz = top;
    return sz;
  endfunction

  task automatic clear_marks();
    low_full   = 1'b0;
    high_full  = 1'b0;
    overrun    = 1'b0;
    mark_valid = 1'b0;
  endtask

  // Writer side: store, advance, set half marks, flag overrun
  task automatic store_byte(input logic [BYTE_W-1:0] b);
    int unsigned half;
    bit          earlier;
    half = ring_len / 2;
    ring_mem[wr_pos] = b;
    wr_pos++;
    if (wr_pos == half) begin
      earlier  = low_full || high_full;
      low_full = 1'b1;
      if (earlier) overrun = 1'b1;
    end
    if (wr_pos >= ring_len) begin
      earlier   = low_full || high_full;
      high_full = 1'b1;
      if (earlier) overrun = 1'b1;
      wr_pos = 0;
    end
  endtask

  // Reader side: overrun, idle marker, byte, or nothing
  task automatic predict_read(output rsp_t ans);
    int unsigned half;
    half           = ring_len / 2;
    ans.status     = ST_NODATA;
    ans.data_byte  = '0;
    if (overrun) begin
      ans.status = ST_OVF;
    end else if (mark_valid && rd_pos == mark_pos) begin
      ans.status = ST_IDLE;
      mark_valid = 1'b0;
    end else if (rd_pos < half) begin
      // last byte of the lower half waits for the half mark
      if (low_full || (rd_pos < wr_pos && rd_pos != half - 1)) begin
        ans.status    = ST_BYTE;
        ans.data_byte = ring_mem[rd_pos];
        rd_pos++;
        if (rd_pos == half) low_full = 1'b0;
      end
    end else if (high_full || rd_pos < wr_pos) begin
      ans.status    = ST_BYTE;
      ans.data_byte = ring_mem[rd_pos];
      rd_pos++;
      if (rd_pos >= ring_len) begin
        rd_pos    = 0;
        high_full = 1'b0;
      end
    end
  endtask

  // Channel monitor
  always @(posedge clk) begin : watch_beats
    rsp_t want;
    rsp_t got;
    if (rst) begin
      ring_len = clamp_len(SIZE_W'(256));
      wr_pos   = 0;
      rd_pos   = 0;
      mark_pos = 0;
      clear_marks();
      due_answers.delete();
    end else begin
      // answers leave before new reads are queued
      if (rsp_valid && !rsp_stall) begin
        got = rsp;
        if (due_answers.size() == 0) begin
          errors++;
          $display("%0t: answer with none due, status %0d data %02h",
                   $time, got.status, got.data_byte);
        end else begin
          want = due_answers.pop_front();
          if (got.status !== want.status) begin
            errors++;
            $display("%0t: status mismatch, expected %0d actual %0d",
                     $time, want.status, got.status);
          end
          if (got.data_byte !== want.data_byte) begin
            errors++;
            $display("%0t: data mismatch, expected %02h actual %02h",
                     $time, want.data_byte, got.data_byte);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        ring_len = clamp_len(cfg_data);
        wr_pos   = 0;
        rd_pos   = 0;
        clear_marks();
      end
      if (req_valid && !req_stall) begin
        case (req.op)
          OP_RX: begin
            store_byte(req.rx_byte);
          end
          OP_IDLE: begin
            mark_valid = 1'b1;
            mark_pos   = wr_pos & 8'hFF;
          end
          OP_FLUSH: begin
            rd_pos = wr_pos;
            clear_marks();
          end
          default: begin
            predict_read(want);
            due_answers.push_back(want);
          end
        endcase
      end
    end
    queued = due_answers.size();
  end

endmodule

// ----- bench/dma_ring_rx_buffer_tb.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// dma_ring_rx_buffer_tb
// Stimulus and verdict for the DMA ring receive buffer.
// ---------------------------------------------------------------------------
// A short directed run covers byte extremes, every operation, the idle
// marker, overrun and flush. Random phases follow, each after a size write
// made while the ring is quiet, with sizes mostly small so the half marks,
// wraps and overruns come often. Both sides pause at random, some phases
// run back to back, and one burst of reads meets a long rsp stall so the
// input side backs up. The checker instance scores every answer.
module dma_ring_rx_buffer_tb;
  import drrb_pkg::*;

  localparam int unsigned DEPTH       = 256;
  localparam int          QUIET_LIMIT = 2000;

  logic              clk;
  logic              rst;
  logic              req_valid;
  logic              req_stall;
  req_t              req;
  logic              rsp_valid;
  logic              rsp_stall;
  rsp_t              rsp;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [SIZE_W-1:0] cfg_data;

  int fail_count;
  int queued;
  int send_gap_max = 19;
  int take_gap_max = 19;
  int long_hold    = 0;
  int quiet_cycles = 0;

  dma_ring_rx_buffer #(
    .STORE_DEPTH(DEPTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  dma_ring_rx_buffer_chk #(
    .STORE_DEPTH(DEPTH)
  ) chk (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .fail_count(fail_count),
    .queued    (queued)
  );

  // 2 ns clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: too long without any beat on any channel
  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[dma_ring_rx_buffer] ERROR");
        $finish;
      end
    end
  end

  // Answer side: random stall before each beat, or a long hold on request
  initial begin : take_answers
    int gap;
    rsp_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold > 0) begin
        gap       = long_hold;
        long_hold = 0;
      end else begin
        gap = $urandom_range(0, take_gap_max);
      end
      if (gap > 0) begin
        rsp_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      rsp_stall <= 1'b0;
      do @(posedge clk); while (!(rsp_valid && !rsp_stall));
    end
  end

  // One request beat; called and returns at a falling edge, valid left high
  task automatic send_beat(input op_t code, input logic [BYTE_W-1:0] b);
    int   gap;
    req_t beat;
    gap          = $urandom_range(0, send_gap_max);
    beat.op      = code;
    beat.rx_byte = b;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req       <= beat;
    req_valid <= 1'b1;
    do @(posedge clk); while (!(req_valid && !req_stall));
    @(negedge clk);
  endtask

  // Stop sending and wait until every answer is in
  task automatic settle();
    req_valid <= 1'b0;
    while (queued != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_size(input logic [SIZE_W-1:0] v);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Main sequence
  initial begin
    rst       = 1'b1;
    req_valid = 1'b0;
    req       = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Directed, reset size: empty read, byte extremes, idle marker, flush
    send_beat(OP_READ, 8'h00);
    send_beat(OP_RX, 8'h00);
    send_beat(OP_RX, 8'hFF);
    send_beat(OP_IDLE, 8'hFF);
    send_beat(OP_RX, 8'h55);
    send_beat(OP_RX, 8'hAA);
    repeat (6) send_beat(OP_READ, 8'hFF);
    send_beat(OP_FLUSH, 8'h00);
    settle();

    // Directed, odd size value: fill the whole ring to overrun, then flush
    write_size(9'd5);
    repeat (4) send_beat(OP_RX, BYTE_W'($urandom_range(0, 255)));
    send_beat(OP_READ, 8'h00);
    send_beat(OP_FLUSH, 8'hFF);
    send_beat(OP_READ, 8'h00);

    // Random phases
    for (int ph = 0; ph < 8; ph++) begin
      int unsigned pick;
      logic [SIZE_W-1:0] size_val;
      settle();
      pick = $urandom_range(0, 9);
      if (ph == 0) size_val = 9'd1;
      else if (ph == 1) size_val = 9'd511;
      else if (pick == 0) size_val = SIZE_W'($urandom_range(0, 1));
      else if (pick == 1) size_val = 9'd256;
      else if (pick == 2) size_val = SIZE_W'($urandom_range(0, 511));
      else size_val = SIZE_W'($urandom_range(2, 20));
      write_size(size_val);
      send_gap_max = (ph % 3 == 1) ? 0 : 19;
      take_gap_max = (ph % 3 == 2) ? 0 : 19;

      // back-to-back reads against a long rsp hold: input must back up
      if (ph == 3) begin
        send_gap_max = 0;
        long_hold    = 60;
        repeat (8) send_beat(OP_RX, BYTE_W'($urandom_range(0, 255)));
        repeat (20) send_beat(OP_READ, BYTE_W'($urandom_range(0, 255)));
        send_gap_max = 19;
      end

      repeat (50) begin
        pick = $urandom_range(0, 99);
        if (pick < 42)
          send_beat(OP_RX, BYTE_W'($urandom_range(0, 255)));
        else if (pick < 86)
          send_beat(OP_READ, BYTE_W'($urandom_range(0, 255)));
        else if (pick < 94)
          send_beat(OP_IDLE, BYTE_W'($urandom_range(0, 255)));
        else
          send_beat(OP_FLUSH, BYTE_W'($urandom_range(0, 255)));
      end
    end

    // Drain and verdict
    req_valid <= 1'b0;
    while (queued != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fail_count == 0)
      $display("[dma_ring_rx_buffer] OK");
    else
      $display("[dma_ring_rx_buffer] ERROR");
    $finish;
  end

endmodule

// ----- files.f -----
src/drrb_pkg.sv
src/drrb_ctrl.sv
src/drrb_datapath.sv
src/dma_ring_rx_buffer.sv
bench/dma_ring_rx_buffer_chk.sv
bench/dma_ring_rx_buffer_tb.sv
